// ----- sv/mmio_instruction_decoder_macros.svh -----
// assertion helpers shared by the decoder rtl
// each expects aclk and aresetn in the scope where it is used
`ifndef MMIO_INSTRUCTION_DECODER_MACROS_SVH
`define MMIO_INSTRUCTION_DECODER_MACROS_SVH

// condition must hold at every edge outside reset
`define MID_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mmio decoder check failed");

// same-cycle implication
`define MID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mmio decoder check failed");

// next-cycle implication
`define MID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mmio decoder check failed");

`endif

// ----- sv/mmio_dec_pkg.sv -----
`timescale 1ns / 1ps

package mmio_dec_pkg;

    typedef struct packed {
        logic [63:0] window_low;
        logic [63:0] window_high;
        logic [4:0]  byte_count;
    } dec_in_t;

    typedef struct packed {
        logic        decode_ok;
        logic [3:0]  instr_length;
        logic        is_store;
        logic [2:0]  access_bytes;
        logic [3:0]  reg_number;
        logic        zext_load;
        logic [2:0]  alu_operation;
        logic        has_immediate;
        logic [31:0] immediate_value;
        logic        memory_is_destination;
    } dec_out_t;

    // prefixes
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] REX_FIRST  = 8'h40;
    localparam logic [7:0] REX_LAST   = 8'h4F;
    localparam logic [7:0] REX_R_MASK = 8'h04;

    // opcodes
    localparam logic [7:0] OPC_ESCAPE   = 8'h0F;
    localparam logic [7:0] OPC2_MOVZX_B = 8'hB6;
    localparam logic [7:0] OPC2_MOVZX_W = 8'hB7;
    localparam logic [7:0] OPC_MOV_ST8  = 8'h88;
    localparam logic [7:0] OPC_MOV_ST   = 8'h89;
    localparam logic [7:0] OPC_MOV_LD8  = 8'h8A;
    localparam logic [7:0] OPC_MOV_LD   = 8'h8B;
    localparam logic [7:0] OPC_ADD_LD   = 8'h03;
    localparam logic [7:0] OPC_OR_LD    = 8'h0B;
    localparam logic [7:0] OPC_AND_LD   = 8'h23;
    localparam logic [7:0] OPC_SUB_LD   = 8'h2B;
    localparam logic [7:0] OPC_XOR_LD   = 8'h33;
    localparam logic [7:0] OPC_CMP_LD   = 8'h3B;
    localparam logic [7:0] OPC_TEST_LD  = 8'h85;
    localparam logic [7:0] OPC_ADD_ST8  = 8'h00;
    localparam logic [7:0] OPC_ADD_ST   = 8'h01;
    localparam logic [7:0] OPC_OR_ST8   = 8'h08;
    localparam logic [7:0] OPC_OR_ST    = 8'h09;
    localparam logic [7:0] OPC_AND_ST8  = 8'h20;
    localparam logic [7:0] OPC_AND_ST   = 8'h21;
    localparam logic [7:0] OPC_SUB_ST8  = 8'h28;
    localparam logic [7:0] OPC_SUB_ST   = 8'h29;
    localparam logic [7:0] OPC_XOR_ST8  = 8'h30;
    localparam logic [7:0] OPC_XOR_ST   = 8'h31;
    localparam logic [7:0] OPC_MOV_IMM8 = 8'hC6;
    localparam logic [7:0] OPC_MOV_IMM  = 8'hC7;
    localparam logic [7:0] OPC_GRP1_8   = 8'h80;
    localparam logic [7:0] OPC_GRP1     = 8'h81;
    localparam logic [7:0] OPC_GRP1_SX  = 8'h83;

    // group 1 extensions in modrm.reg
    localparam logic [2:0] GRP1_ADD = 3'd0;
    localparam logic [2:0] GRP1_OR  = 3'd1;
    localparam logic [2:0] GRP1_AND = 3'd4;
    localparam logic [2:0] GRP1_SUB = 3'd5;
    localparam logic [2:0] GRP1_XOR = 3'd6;

    // modrm fields
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_RIPREL  = 3'd5;

    // alu operation codes
    localparam logic [2:0] ALU_MOV  = 3'd0;
    localparam logic [2:0] ALU_ADD  = 3'd1;
    localparam logic [2:0] ALU_OR   = 3'd2;
    localparam logic [2:0] ALU_AND  = 3'd3;
    localparam logic [2:0] ALU_SUB  = 3'd4;
    localparam logic [2:0] ALU_XOR  = 3'd5;
    localparam logic [2:0] ALU_CMP  = 3'd6;
    localparam logic [2:0] ALU_TEST = 3'd7;

    // access sizes in bytes
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;
    localparam logic [2:0] SIZE_DWORD = 3'd4;

    localparam logic [31:0] IMM_SIGN_FILL = 32'hFFFF_FF00;

endpackage

// ----- sv/mmio_dec_core.sv -----
`timescale 1ns / 1ps

module mmio_dec_core
    import mmio_dec_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
) (
    input  dec_in_t  item,
    output dec_out_t result
);

    localparam logic [4:0] WIN_COUNT = 5'(WINDOW_BYTES);

    logic [7:0]  win_b [16];
    logic [4:0]  cnt;
    logic        has_66;
    logic [3:0]  rex_at;
    logic [7:0]  rex_byte;
    logic        has_rex;
    logic        rex_r;
    logic [3:0]  opc_at;
    logic [7:0]  opc;
    logic [7:0]  opc2;
    logic        is_esc;
    logic [3:0]  modrm_at;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [2:0]  raw;
    logic [3:0]  reg_full;
    logic        prefix_ok;
    logic [2:0]  span_base;
    logic [2:0]  span;
    logic [4:0]  end_at;
    logic        span_ok;
    logic [2:0]  wide;
    logic [2:0]  imm_len;
    logic [4:0]  imm_end;
    logic [3:0]  imm_at;
    logic [31:0] imm_word;
    logic        ok;
    dec_out_t    res;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            win_b[k]     = item.window_low[8*k +: 8];
            win_b[k + 8] = item.window_high[8*k +: 8];
        end
    end

    assign cnt = (item.byte_count > WIN_COUNT) ? WIN_COUNT : item.byte_count;

    // prefix walk: optional 0x66, optional rex, opcode, optional second opcode byte
    assign has_66   = win_b[0] == PFX_OPSIZE;
    assign rex_at   = {3'b000, has_66};
    assign rex_byte = win_b[rex_at];
    assign has_rex  = (rex_byte >= REX_FIRST) && (rex_byte <= REX_LAST);
    assign rex_r    = has_rex && ((rex_byte & REX_R_MASK) != 8'h00);
    assign opc_at   = rex_at + {3'b000, has_rex};
    assign opc      = win_b[opc_at];
    assign opc2     = win_b[opc_at + 4'd1];
    assign is_esc   = opc == OPC_ESCAPE;
    assign modrm_at = is_esc ? (opc_at + 4'd2) : (opc_at + 4'd1);

    assign prefix_ok = ({1'b0, rex_at} < cnt) && ({1'b0, opc_at} < cnt)
                    && ({1'b0, modrm_at} < cnt);

    // addressing bytes
    assign modrm    = win_b[modrm_at];
    assign sib      = win_b[modrm_at + 4'd1];
    assign mod_f    = modrm[7:6];
    assign rm_f     = modrm[2:0];
    assign raw      = modrm[5:3];
    assign reg_full = {rex_r, raw};

    always_comb begin
        span_base = 3'd1;
        if (rm_f == RM_SIB) begin
            span_base = ((mod_f == MOD_NODISP) && (sib[2:0] == RM_RIPREL)) ? 3'd6 : 3'd2;
        end else if ((mod_f == MOD_NODISP) && (rm_f == RM_RIPREL)) begin
            span_base = 3'd5;
        end
        case (mod_f)
            MOD_DISP8:  span = span_base + 3'd1;
            MOD_DISP32: span = span_base + 3'd4;
            default:    span = span_base;
        endcase
    end

    assign end_at  = {1'b0, modrm_at} + {2'b00, span};
    assign span_ok = (mod_f != MOD_REG)
                  && ((rm_f != RM_SIB) || (({1'b0, modrm_at} + 5'd1) < cnt))
                  && (end_at <= cnt);

    // immediate bytes follow the addressing bytes
    assign wide    = has_66 ? SIZE_WORD : SIZE_DWORD;
    assign imm_len = ((opc == OPC_MOV_IMM8) || (opc == OPC_GRP1_8) || (opc == OPC_GRP1_SX))
                   ? SIZE_BYTE : wide;
    assign imm_end = end_at + {2'b00, imm_len};
    assign imm_at  = end_at[3:0];

    always_comb begin
        case (imm_len)
            SIZE_BYTE: imm_word = {24'h0, win_b[imm_at]};
            SIZE_WORD: imm_word = {16'h0, win_b[imm_at + 4'd1], win_b[imm_at]};
            default:   imm_word = {win_b[imm_at + 4'd3], win_b[imm_at + 4'd2],
                                   win_b[imm_at + 4'd1], win_b[imm_at]};
        endcase
    end

    always_comb begin
        res              = '0;
        ok               = prefix_ok && span_ok;
        res.instr_length = end_at[3:0];
        res.reg_number   = reg_full;
        if (is_esc) begin
            if ((opc2 != OPC2_MOVZX_B) && (opc2 != OPC2_MOVZX_W)) begin
                ok = 1'b0;
            end
            res.access_bytes = (opc2 == OPC2_MOVZX_B) ? SIZE_BYTE : SIZE_WORD;
            res.zext_load    = 1'b1;
        end else begin
            case (opc)
                OPC_MOV_ST8, OPC_MOV_LD8: begin
                    if (!has_rex && raw[2]) begin
                        ok = 1'b0;
                    end
                    res.is_store     = opc == OPC_MOV_ST8;
                    res.access_bytes = SIZE_BYTE;
                end
                OPC_MOV_ST: begin
                    res.is_store     = 1'b1;
                    res.access_bytes = wide;
                end
                OPC_MOV_LD: begin
                    res.access_bytes = wide;
                    res.zext_load    = !has_66;
                end
                OPC_ADD_LD, OPC_OR_LD, OPC_AND_LD, OPC_SUB_LD,
                OPC_XOR_LD, OPC_CMP_LD, OPC_TEST_LD: begin
                    res.access_bytes = wide;
                    case (opc)
                        OPC_ADD_LD: res.alu_operation = ALU_ADD;
                        OPC_OR_LD:  res.alu_operation = ALU_OR;
                        OPC_AND_LD: res.alu_operation = ALU_AND;
                        OPC_SUB_LD: res.alu_operation = ALU_SUB;
                        OPC_XOR_LD: res.alu_operation = ALU_XOR;
                        OPC_CMP_LD: res.alu_operation = ALU_CMP;
                        default:    res.alu_operation = ALU_TEST;
                    endcase
                end
                OPC_MOV_IMM8, OPC_MOV_IMM: begin
                    // rex.r does not take part in the /0 check
                    if ((raw != GRP1_ADD) || (imm_end > cnt)) begin
                        ok = 1'b0;
                    end
                    res.access_bytes    = imm_len;
                    res.is_store        = 1'b1;
                    res.reg_number      = 4'd0;
                    res.has_immediate   = 1'b1;
                    res.immediate_value = imm_word;
                    res.instr_length    = imm_end[3:0];
                end
                OPC_ADD_ST8, OPC_OR_ST8, OPC_AND_ST8, OPC_SUB_ST8, OPC_XOR_ST8,
                OPC_ADD_ST, OPC_OR_ST, OPC_AND_ST, OPC_SUB_ST, OPC_XOR_ST: begin
                    if (!opc[0] && !has_rex && raw[2]) begin
                        ok = 1'b0;
                    end
                    res.is_store              = 1'b1;
                    res.memory_is_destination = 1'b1;
                    res.access_bytes          = opc[0] ? wide : SIZE_BYTE;
                    case ({opc[7:1], 1'b0})
                        OPC_ADD_ST8: res.alu_operation = ALU_ADD;
                        OPC_OR_ST8:  res.alu_operation = ALU_OR;
                        OPC_AND_ST8: res.alu_operation = ALU_AND;
                        OPC_SUB_ST8: res.alu_operation = ALU_SUB;
                        default:     res.alu_operation = ALU_XOR;
                    endcase
                end
                OPC_GRP1_8, OPC_GRP1, OPC_GRP1_SX: begin
                    case (raw)
                        GRP1_ADD: res.alu_operation = ALU_ADD;
                        GRP1_OR:  res.alu_operation = ALU_OR;
                        GRP1_AND: res.alu_operation = ALU_AND;
                        GRP1_SUB: res.alu_operation = ALU_SUB;
                        GRP1_XOR: res.alu_operation = ALU_XOR;
                        default:  ok = 1'b0;
                    endcase
                    if (imm_end > cnt) begin
                        ok = 1'b0;
                    end
                    res.access_bytes          = (opc == OPC_GRP1_8) ? SIZE_BYTE : wide;
                    res.is_store              = 1'b1;
                    res.memory_is_destination = 1'b1;
                    res.reg_number            = 4'd0;
                    res.has_immediate         = 1'b1;
                    res.immediate_value       = imm_word;
                    if ((opc == OPC_GRP1_SX) && imm_word[7]) begin
                        res.immediate_value = imm_word | IMM_SIGN_FILL;
                    end
                    res.instr_length = imm_end[3:0];
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok) begin
            res = '0;
        end
        res.decode_ok = ok;
    end

    assign result = res;

endmodule

// ----- sv/mmio_instruction_decoder.sv -----
`timescale 1ns / 1ps
//  channel  dir  handshake           payload    carries
//  s_       in   s_valid / s_ready   s_data     16-byte window and valid byte count
//  m_       out  m_valid / m_ready   m_data     one decode result per transaction
//
//  one transaction per cycle sustained while m_ready is high; a window accepted on s_ is
//  decoded and its result presented on m_ through the register stages
//  (input register, single-pass decode logic, result register)
//  aresetn is synchronous, active low, and empties both register stages
//  a stalled m_ side keeps its result; s_ready drops only while both stages hold data
//  and m_ready is low

`include "mmio_instruction_decoder_macros.svh"

module mmio_instruction_decoder
    import mmio_dec_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dec_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dec_out_t m_data
);

    // input stage
    logic     in_valid_reg;
    logic     in_valid_next;
    dec_in_t  in_data_reg;
    dec_in_t  in_data_next;

    // result stage
    logic     out_valid_reg;
    logic     out_valid_next;
    dec_out_t out_data_reg;
    dec_out_t out_data_next;

    dec_out_t dec_result;
    logic     out_adv;
    logic     s_take;
    logic     out_size_legal;

    // whole decode of the held window, no state of its own
    mmio_dec_core #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_core (
        .item   (in_data_reg),
        .result (dec_result)
    );

    // result register moves when empty or when its transaction is taken
    assign out_adv = !out_valid_reg || m_ready;
    // input register frees up in the same cycle it hands its window on
    assign s_ready = !in_valid_reg || out_adv;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_adv) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
            if (in_valid_reg) begin
                out_data_next = dec_result;
            end
        end
        if (s_take) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign out_size_legal = (out_data_reg.access_bytes == SIZE_BYTE)
                         || (out_data_reg.access_bytes == SIZE_WORD)
                         || (out_data_reg.access_bytes == SIZE_DWORD);

    // a rejected window leaves nothing but zeros
    `MID_ASSERT_IMP(a_reject_all_zero, out_valid_reg && !out_data_reg.decode_ok, out_data_reg == '0)
    // a good decode always has a real size and length
    `MID_ASSERT_IMP(a_good_has_size, out_valid_reg && out_data_reg.decode_ok, out_size_legal && (out_data_reg.instr_length != 4'd0))
    // read-modify-write always writes the device
    `MID_ASSERT_IMP(a_rmw_is_store, out_valid_reg && out_data_reg.memory_is_destination, out_data_reg.is_store)
    // a held window is not dropped or overwritten while the result stage is blocked
    `MID_ASSERT_NEXT(a_stage_kept, in_valid_reg && !out_adv, in_valid_reg && $stable(in_data_reg))
    // back-pressure only when both stages are occupied
    `MID_ASSERT_HOLDS(a_ready_when_room, s_ready || (in_valid_reg && out_valid_reg))

endmodule

// ----- tb/mmio_decode_checker.sv -----
`timescale 1ns / 1ps

module mmio_decode_checker
    import mmio_dec_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  dec_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  dec_out_t m_data,
    output int       fail_count,
    output int       pending,
    output int       result_count,
    output int       decoded_count
);

    localparam int MAX_PRINTED = 40;

    dec_out_t expected_decodes[$];

    function automatic logic [7:0] window_byte(dec_in_t w, int k);
        if (k < 8) begin
            return w.window_low[8*k +: 8];
        end
        if (k < 16) begin
            return w.window_high[8*(k-8) +: 8];
        end
        return 8'h00;
    endfunction

    // modrm + optional sib + displacement; 0 when register-direct or short
    function automatic bit address_span(dec_in_t w, int at, int n, output int span);
        logic [7:0] modrm;
        logic [7:0] sib;
        int t;
        modrm = window_byte(w, at);
        sib   = window_byte(w, at + 1);
        t     = 1;
        span  = 0;
        if (modrm[7:6] == MOD_REG) begin
            return 1'b0;
        end
        if (modrm[2:0] == RM_SIB) begin
            if (at + 1 >= n) begin
                return 1'b0;
            end
            t++;
            // sib base 5 under mod 0 carries a disp32 instead of a base
            if (modrm[7:6] == MOD_NODISP && sib[2:0] == RM_RIPREL) begin
                t += 4;
            end
        end else if (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_RIPREL) begin
            t += 4;
        end
        if (modrm[7:6] == MOD_DISP8) begin
            t += 1;
        end else if (modrm[7:6] == MOD_DISP32) begin
            t += 4;
        end
        if (at + t > n) begin
            return 1'b0;
        end
        span = t;
        return 1'b1;
    endfunction

    function automatic logic [31:0] immediate_at(dec_in_t w, int at, int len);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < len && k < 4; k++) begin
            v[8*k +: 8] = window_byte(w, at + k);
        end
        return v;
    endfunction

    function automatic dec_out_t predict_decode(dec_in_t w);
        dec_out_t   r;
        dec_out_t   rejected;
        int         n, i, at, span, stop, imm_len;
        logic [7:0] opc, opc2, modrm, pfx;
        logic [2:0] raw, wide;
        logic [3:0] rex_r_bit;
        bit         o16, rex, byte_form;
        r        = '0;
        rejected = '0;
        n = int'(w.byte_count);
        if (n > WINDOW_BYTES) begin
            n = WINDOW_BYTES;
        end
        if (n == 0) begin
            return rejected;
        end
        i         = 0;
        o16       = 1'b0;
        rex       = 1'b0;
        rex_r_bit = 4'h0;
        if (window_byte(w, 0) == PFX_OPSIZE) begin
            o16 = 1'b1;
            i   = 1;
        end
        if (i >= n) begin
            return rejected;
        end
        pfx = window_byte(w, i);
        if (pfx >= REX_FIRST && pfx <= REX_LAST) begin
            rex       = 1'b1;
            rex_r_bit = ((pfx & REX_R_MASK) != 8'h00) ? 4'h8 : 4'h0;
            i++;
        end
        if (i >= n) begin
            return rejected;
        end
        opc  = window_byte(w, i);
        i++;
        wide = o16 ? SIZE_WORD : SIZE_DWORD;

        if (opc == OPC_ESCAPE) begin
            if (i >= n) begin
                return rejected;
            end
            opc2 = window_byte(w, i);
            i++;
            if (i >= n) begin
                return rejected;
            end
            if (!address_span(w, i, n, span)) begin
                return rejected;
            end
            if (opc2 != OPC2_MOVZX_B && opc2 != OPC2_MOVZX_W) begin
                return rejected;
            end
            modrm          = window_byte(w, i);
            r.decode_ok    = 1'b1;
            r.instr_length = 4'(i + span);
            r.access_bytes = (opc2 == OPC2_MOVZX_B) ? SIZE_BYTE : SIZE_WORD;
            r.reg_number   = {1'b0, modrm[5:3]} | rex_r_bit;
            r.zext_load    = 1'b1;
            return r;
        end

        at = i;
        if (!address_span(w, at, n, span)) begin
            return rejected;
        end
        modrm          = window_byte(w, at);
        raw            = modrm[5:3];
        stop           = at + span;
        r.decode_ok    = 1'b1;
        r.instr_length = 4'(stop);
        r.reg_number   = {1'b0, raw} | rex_r_bit;

        case (opc)
            OPC_MOV_ST8, OPC_MOV_LD8: begin
                if (!rex && raw >= 3'd4) begin
                    return rejected;
                end
                r.is_store     = (opc == OPC_MOV_ST8);
                r.access_bytes = SIZE_BYTE;
            end
            OPC_MOV_ST: begin
                r.is_store     = 1'b1;
                r.access_bytes = wide;
            end
            OPC_MOV_LD: begin
                r.access_bytes = wide;
                r.zext_load    = !o16;
            end
            OPC_ADD_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_ADD;
            end
            OPC_OR_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_OR;
            end
            OPC_AND_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_AND;
            end
            OPC_SUB_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_SUB;
            end
            OPC_XOR_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_XOR;
            end
            OPC_CMP_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_CMP;
            end
            OPC_TEST_LD: begin
                r.access_bytes  = wide;
                r.alu_operation = ALU_TEST;
            end
            OPC_MOV_IMM8, OPC_MOV_IMM: begin
                if (raw != GRP1_ADD) begin
                    return rejected;
                end
                imm_len = (opc == OPC_MOV_IMM8) ? 1 : int'(wide);
                if (stop + imm_len > n) begin
                    return rejected;
                end
                r.access_bytes    = 3'(imm_len);
                r.is_store        = 1'b1;
                r.reg_number      = 4'h0;
                r.has_immediate   = 1'b1;
                r.immediate_value = immediate_at(w, stop, imm_len);
                r.instr_length    = 4'(stop + imm_len);
            end
            OPC_ADD_ST8, OPC_OR_ST8, OPC_AND_ST8, OPC_SUB_ST8, OPC_XOR_ST8,
            OPC_ADD_ST, OPC_OR_ST, OPC_AND_ST, OPC_SUB_ST, OPC_XOR_ST: begin
                byte_form = !opc[0];
                if (byte_form && !rex && raw >= 3'd4) begin
                    return rejected;
                end
                r.is_store              = 1'b1;
                r.memory_is_destination = 1'b1;
                r.access_bytes          = byte_form ? SIZE_BYTE : wide;
                case ({opc[7:1], 1'b0})
                    OPC_ADD_ST8: r.alu_operation = ALU_ADD;
                    OPC_OR_ST8:  r.alu_operation = ALU_OR;
                    OPC_AND_ST8: r.alu_operation = ALU_AND;
                    OPC_SUB_ST8: r.alu_operation = ALU_SUB;
                    default:     r.alu_operation = ALU_XOR;
                endcase
            end
            OPC_GRP1_8, OPC_GRP1, OPC_GRP1_SX: begin
                case (raw)
                    GRP1_ADD: r.alu_operation = ALU_ADD;
                    GRP1_OR:  r.alu_operation = ALU_OR;
                    GRP1_AND: r.alu_operation = ALU_AND;
                    GRP1_SUB: r.alu_operation = ALU_SUB;
                    GRP1_XOR: r.alu_operation = ALU_XOR;
                    default:  return rejected;
                endcase
                imm_len = (opc == OPC_GRP1) ? int'(wide) : 1;
                if (stop + imm_len > n) begin
                    return rejected;
                end
                r.access_bytes          = (opc == OPC_GRP1_8) ? SIZE_BYTE : wide;
                r.is_store              = 1'b1;
                r.memory_is_destination = 1'b1;
                r.reg_number            = 4'h0;
                r.has_immediate         = 1'b1;
                r.immediate_value       = immediate_at(w, stop, imm_len);
                if (opc == OPC_GRP1_SX && r.immediate_value[7]) begin
                    r.immediate_value = r.immediate_value | IMM_SIGN_FILL;
                end
                r.instr_length          = 4'(stop + imm_len);
            end
            default: begin
                return rejected;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %h expected %h",
                                      result_count, name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        dec_out_t want;
        if (!aresetn) begin
            expected_decodes.delete();
            fail_count    = 0;
            pending       = 0;
            result_count  = 0;
            decoded_count = 0;
        end else begin
            // a result never leaves at the edge its window is taken, so pop first
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_decodes.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no window outstanding",
                                              result_count));
                end else begin
                    want = expected_decodes.pop_front();
                    if (want.decode_ok) begin
                        decoded_count++;
                    end
                    check_field("decode_ok", 32'(m_data.decode_ok), 32'(want.decode_ok));
                    check_field("instr_length", 32'(m_data.instr_length),
                                32'(want.instr_length));
                    check_field("is_store", 32'(m_data.is_store), 32'(want.is_store));
                    check_field("access_bytes", 32'(m_data.access_bytes),
                                32'(want.access_bytes));
                    check_field("reg_number", 32'(m_data.reg_number), 32'(want.reg_number));
                    check_field("zext_load", 32'(m_data.zext_load),
                                32'(want.zext_load));
                    check_field("alu_operation", 32'(m_data.alu_operation),
                                32'(want.alu_operation));
                    check_field("has_immediate", 32'(m_data.has_immediate),
                                32'(want.has_immediate));
                    check_field("immediate_value", m_data.immediate_value,
                                want.immediate_value);
                    check_field("memory_is_destination", 32'(m_data.memory_is_destination),
                                32'(want.memory_is_destination));
                end
            end
            if (s_valid && s_ready) begin
                expected_decodes.push_back(predict_decode(s_data));
            end
            pending = expected_decodes.size();
        end
    end

endmodule

// ----- tb/tb_mmio_instruction_decoder.sv -----
`timescale 1ns / 1ps

module tb_mmio_instruction_decoder;
    import mmio_dec_pkg::*;

    localparam int WINDOW_BYTES  = 16;
    localparam int RANDOM_ITEMS  = 630;
    localparam int DIRECTED_SENT = 24;
    // long output hold-off, well past the two register stages of the block
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // every opcode the block claims to handle, picked at random below
    localparam logic [7:0] OPCODE_SET [27] = '{
        OPC_ESCAPE,
        OPC_MOV_ST8, OPC_MOV_ST, OPC_MOV_LD8, OPC_MOV_LD,
        OPC_ADD_LD, OPC_OR_LD, OPC_AND_LD, OPC_SUB_LD, OPC_XOR_LD, OPC_CMP_LD, OPC_TEST_LD,
        OPC_ADD_ST8, OPC_ADD_ST, OPC_OR_ST8, OPC_OR_ST, OPC_AND_ST8, OPC_AND_ST,
        OPC_SUB_ST8, OPC_SUB_ST, OPC_XOR_ST8, OPC_XOR_ST,
        OPC_MOV_IMM8, OPC_MOV_IMM,
        OPC_GRP1_8, OPC_GRP1, OPC_GRP1_SX
    };

    // clock, reset and every block input start at known values
    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dec_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dec_out_t m_data;

    int fail_count;
    int pending;
    int result_count;
    int decoded_count;
    int cycle_count = 0;

    // set by the stimulus, served and cleared by the receiver
    bit output_hold_req = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    mmio_instruction_decoder #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // watches both channels, predicts each decode and compares
    mmio_decode_checker #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) checker_inst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .decoded_count(decoded_count)
    );

    // builds a window from bytes written in instruction order, rest zero
    function automatic dec_in_t from_text(logic [127:0] seq, int nbytes, int count);
        dec_in_t    w;
        logic [7:0] b;
        w = '0;
        for (int k = 0; k < nbytes; k++) begin
            b = seq[8*(nbytes-1-k) +: 8];
            if (k < 8) begin
                w.window_low[8*k +: 8] = b;
            end else begin
                w.window_high[8*(k-8) +: 8] = b;
            end
        end
        w.byte_count = 5'(count);
        return w;
    endfunction

    // offer one transaction and hold it until the block takes it; valid stays high
    task automatic send_item(input dec_in_t item);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver: runs through randomly chosen stall patterns, with a long hold-off on request
    initial begin : receiver
        int mode;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 64; k++) begin
                @(negedge aclk);
                if (output_hold_req) begin
                    // block fills up behind this and must stall its input
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    m_ready <= 1'b1;
                    output_hold_req = 1'b0;
                end else begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= (k % 3 != 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] b [16];
        dec_in_t    item;
        logic [7:0] opc;
        int         pos, burst_left, gap;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, each operation class and each rejection reason
        send_item(from_text(128'h0, 0, 0));                       // empty window
        send_item(from_text(128'h0, 0, 16));                      // all zero: add byte to mem
        send_item('{window_low: '1, window_high: '1, byte_count: 5'h1F}); // count saturates
        send_item(from_text(128'h8B_C0, 2, 2));                   // register-direct modrm
        send_item(from_text(128'h8B_80_11_22_33, 5, 5));          // disp32 cut short
        send_item(from_text(128'h88_20, 2, 2));                   // high-byte reg, no rex
        send_item(from_text(128'h40_88_20, 3, 3));                // same with rex present
        send_item(from_text(128'h44_8B_38, 3, 16));               // rex.r gives reg 15
        send_item(from_text(128'h48_89_00, 3, 16));               // rex.w has no effect
        send_item(from_text(128'h66_89_00, 3, 16));               // 16-bit store
        send_item(from_text(128'h0F_B6_04_25_78_56_34_12, 8, 8)); // movzx, sib no base
        send_item(from_text(128'h66_0F_B7_00, 4, 4));             // opsize on movzx ignored
        send_item(from_text(128'h0F_B8_00, 3, 16));               // bad second opcode
        send_item(from_text(128'h03_05_EF_BE_AD_DE, 6, 6));       // rip-relative add
        send_item(from_text(128'h3B_44_24_08, 4, 4));             // cmp with sib + disp8
        send_item(from_text(128'h85_00, 2, 2));                   // test
        send_item(from_text(128'h29_84_24_01_00_00_80, 7, 16));   // sub to mem, sib disp32
        send_item(from_text(128'hC6_00_7F, 3, 3));                // mov imm8
        send_item(from_text(128'h66_C7_40_10_34_12, 6, 6));       // mov imm16
        send_item(from_text(128'hC7_08_00_00_00_00, 6, 16));     // mov imm with /1
        send_item(from_text(128'h80_00_FF, 3, 3));                // add imm8 byte
        send_item(from_text(128'h81_08_78_56_34_12, 6, 6));       // or imm32
        send_item(from_text(128'h83_28_80, 3, 16));               // sub sign-extended imm
        send_item(from_text(128'h83_10_01, 3, 16));               // group 1 /2

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) begin
                output_hold_req = 1'b1;
            end
            if (n == 420) begin
                // sender pauses until the block has returned every result
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end

            if ($urandom_range(0, 99) < 85) begin
                // well-formed shape with random content; trailing bytes stay random
                for (int k = 0; k < 16; k++) begin
                    b[k] = 8'($urandom);
                end
                pos = 0;
                if ($urandom_range(0, 2) == 0) begin
                    b[pos] = PFX_OPSIZE;
                    pos++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    b[pos] = REX_FIRST + 8'($urandom_range(0, 15));
                    pos++;
                end
                opc = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                   : OPCODE_SET[$urandom_range(0, 26)];
                b[pos] = opc;
                pos++;
                if (opc == OPC_ESCAPE) begin
                    if ($urandom_range(0, 7) == 0) begin
                        b[pos] = 8'($urandom);
                    end else begin
                        b[pos] = $urandom_range(0, 1) ? OPC2_MOVZX_B : OPC2_MOVZX_W;
                    end
                    pos++;
                end
                // modrm: mostly memory forms, sib often, immediate moves mostly /0
                if ($urandom_range(0, 9) != 0) begin
                    b[pos][7:6] = 2'($urandom_range(0, 2));
                end
                if ($urandom_range(0, 3) == 0) begin
                    b[pos][2:0] = RM_SIB;
                end
                if ((opc == OPC_MOV_IMM8 || opc == OPC_MOV_IMM) && $urandom_range(0, 3) != 0)
                begin
                    b[pos][5:3] = GRP1_ADD;
                end
                for (int k = 0; k < 8; k++) begin
                    item.window_low[8*k +: 8]  = b[k];
                    item.window_high[8*k +: 8] = b[k+8];
                end
                case ($urandom_range(0, 9))
                    6, 7:    item.byte_count = 5'($urandom_range(17, 31));
                    8, 9:    item.byte_count = 5'($urandom_range(0, 16));
                    default: item.byte_count = 5'(WINDOW_BYTES);
                endcase
            end else begin
                // plain noise across the whole window and count
                item.window_low  = {$urandom, $urandom};
                item.window_high = {$urandom, $urandom};
                item.byte_count  = 5'($urandom);
            end

            // bursts of random length, with a gap before most of them
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0) begin
                    gap = $urandom_range(1, 12);
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            burst_left--;
            send_item(item);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d windows (%0d directed): %0d decoded, %0d rejected",
                 result_count, DIRECTED_SENT, decoded_count, result_count - decoded_count);
        $display("with sender bursts, four receiver stall patterns, a %0d-cycle hold-off %s",
                 HOLD_CYCLES, "and a full drain mid-run");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mmio_dec_pkg.sv
sv/mmio_dec_core.sv
sv/mmio_instruction_decoder.sv
tb/mmio_decode_checker.sv
tb/tb_mmio_instruction_decoder.sv
